// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the convolver core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CFWC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("convolver core check failed");

// Checked on every rising clock edge, reset included.
`define CFWC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("convolver core check failed");

`endif

// ===== rtl/core/cfwc_pkg.sv =====
// ---------------------------------------------------------------------------
// Convolver core package
// Sizes, command and register codes, and types shared by the core modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfwc_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int FIELD_BITS  = 16;
  localparam int ACC_W       = 40;
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
  localparam int TERM_W      = PROD_W + 1;
  localparam int POS_W       = 16;
  localparam int CNT_W       = 17;
  localparam int TAP_COUNT_W = 7;
  localparam int TAP_INDEX_W = 6;
  localparam int CMD_W       = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 96;

  localparam logic [CNT_W-1:0] POS_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_LOAD   = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_SAMPLE = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_FLUSH  = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_W'(3);

  localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_TAPS_REAL    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN   = CFG_INDEX_W'(3);

  typedef struct packed {
    logic                    valid;
    logic signed [ACC_W-1:0] i;
    logic signed [ACC_W-1:0] q;
  } wave_t;

  typedef struct packed {
    logic                   shift;
    logic                   clear;
    logic                   load;
    logic                   zero_in;
    logic                   real_mode;
    logic [TAP_COUNT_W-1:0] tap_count;
  } cell_ctrl_t;

  function automatic logic signed [SAMPLE_BITS-1:0] to_hist(input logic [FIELD_BITS-1:0] raw);
    logic [31:0] wide;
    wide = 32'(raw);
    return wide[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/cfwc_cell.sv =====
// ---------------------------------------------------------------------------
// Convolver cell
// Holds one history sample and one tap, forms their product term, and adds
// it to the partial sum that walks down the chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfwc_cell
  import cfwc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic signed [SAMPLE_BITS-1:0] hist_in_i,
  input  logic signed [SAMPLE_BITS-1:0] hist_in_q,
  input  logic                          load,
  input  logic signed [COEF_BITS-1:0]   coef_i,
  input  logic signed [COEF_BITS-1:0]   coef_q,
  input  logic                          real_mode,
  input  logic                          active,
  input  wave_t                         wave_in,
  output logic signed [SAMPLE_BITS-1:0] hist_i,
  output logic signed [SAMPLE_BITS-1:0] hist_q,
  output wave_t                         wave_out
);

  logic signed [COEF_BITS-1:0] tap_i;
  logic signed [COEF_BITS-1:0] tap_q;
  logic signed [PROD_W-1:0]    p_ii;
  logic signed [PROD_W-1:0]    p_qq;
  logic signed [PROD_W-1:0]    p_iq;
  logic signed [PROD_W-1:0]    p_qi;
  logic signed [TERM_W-1:0]    term_i;
  logic signed [TERM_W-1:0]    term_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_i <= '0;
      hist_q <= '0;
    end else if (shift) begin
      hist_i <= hist_in_i;
      hist_q <= hist_in_q;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tap_i <= coef_i;
      tap_q <= coef_q;
    end
  end

  always_ff @(posedge clk) begin
    p_ii <= hist_i * tap_i;
    p_qq <= hist_q * tap_q;
    p_iq <= hist_i * tap_q;
    p_qi <= hist_q * tap_i;
  end

  always_ff @(posedge clk) begin
    if (!active) begin
      term_i <= '0;
      term_q <= '0;
    end else if (real_mode) begin
      term_i <= TERM_W'(p_ii);
      term_q <= TERM_W'(p_qi);
    end else begin
      term_i <= TERM_W'(p_ii) - TERM_W'(p_qq);
      term_q <= TERM_W'(p_iq) + TERM_W'(p_qi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= wave_in.valid;
    end
    wave_out.i <= wave_in.i + ACC_W'(term_i);
    wave_out.q <= wave_in.q + ACC_W'(term_q);
  end

endmodule

// ===== rtl/core/cfwc_ctrl.sv =====
// ---------------------------------------------------------------------------
// Convolver control
// Configuration registers, request handshake, position tracking, launch of
// the partial sum into the chain and the result output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfwc_ctrl
  import cfwc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [CMD_W-1:0]              cmd,
  input  logic                          first_sample,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic signed [ACC_W-1:0]       out_i,
  output logic signed [ACC_W-1:0]       out_q,
  output logic [POS_W-1:0]              out_pos,
  output cell_ctrl_t                    ctl,
  output wave_t                         start,
  input  wave_t                         tail
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t                  state;
  logic [TAP_COUNT_W-1:0]  tap_count;
  logic                    taps_real;
  logic [POS_W-1:0]        window_start;
  logic [POS_W-1:0]        window_len;
  logic [CNT_W-1:0]        pos_cnt;
  logic [2:0]              launch;
  logic                    emit_pend;
  logic [POS_W-1:0]        pos_pend;
  logic signed [ACC_W-1:0] res_i;
  logic signed [ACC_W-1:0] res_q;

  logic                    accept;
  logic [CNT_W-1:0]        p;
  logic [CNT_W-1:0]        p_next;
  logic [CNT_W-1:0]        diff;
  logic                    emit;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    ctl.shift     = accept && ((cmd == CMD_SAMPLE) || (cmd == CMD_FLUSH));
    ctl.clear     = first_sample;
    ctl.load      = accept && (cmd == CMD_LOAD);
    ctl.zero_in   = (cmd != CMD_SAMPLE);
    ctl.real_mode = taps_real;
    ctl.tap_count = tap_count;
  end

  always_comb begin
    start.valid = launch[2];
    start.i     = '0;
    start.q     = '0;
  end

  always_comb begin
    p      = first_sample ? '0 : pos_cnt;
    p_next = (p < POS_MAX) ? p + CNT_W'(1) : p;
    diff   = p - CNT_W'(window_start);
    emit   = (p >= CNT_W'(window_start)) && (diff < CNT_W'(window_len));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tap_count    <= TAP_COUNT_W'(1);
      taps_real    <= 1'b0;
      window_start <= '0;
      window_len   <= '0;
      pos_cnt      <= '0;
      launch       <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TAP_COUNT:    tap_count    <= cfg_data[TAP_COUNT_W-1:0];
          REG_TAPS_REAL:    taps_real    <= cfg_data[0];
          REG_WINDOW_START: window_start <= cfg_data[POS_W-1:0];
          REG_WINDOW_LEN:   window_len   <= cfg_data[POS_W-1:0];
          default: ;
        endcase
      end

      launch <= {launch[1:0], ctl.shift};

      if (m_tvalid && m_tready && (state != ST_HOLD)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (ctl.shift) begin
            pos_cnt   <= p_next;
            emit_pend <= emit;
            pos_pend  <= diff[POS_W-1:0];
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tail.valid) begin
            res_i <= tail.i;
            res_q <= tail.q;
            state <= emit_pend ? ST_HOLD : ST_IDLE;
          end
        end
        ST_HOLD: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_i    <= res_i;
            out_q    <= res_q;
            out_pos  <= pos_pend;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/complex_fir_windowed_convolver_core.sv =====
// ---------------------------------------------------------------------------
// Complex FIR windowed convolver core
// Full linear convolution of complex samples with a loaded tap set, emitting
// only the positions that fall inside a configured window.
// ---------------------------------------------------------------------------
// A tap load or an unused command leaves the core ready for the next request.
// A sample or flush request keeps out the next request until its partial
// sum has walked the row of tap cells one cell per clock, and, when it gives
// a result, until that result is stored. The result sits in an output
// register, so a new request is taken while it waits to be read.
`timescale 1ns / 1ps

module complex_fir_windowed_convolver_core
  import cfwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tap_index, coef_i, coef_q, sample_i, sample_q, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // cmd, first_sample
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_i, out_q, out_pos
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [TAP_INDEX_W-1:0]        tap_index;
  logic signed [COEF_BITS-1:0]   coef_i;
  logic signed [COEF_BITS-1:0]   coef_q;
  logic signed [SAMPLE_BITS-1:0] new_i;
  logic signed [SAMPLE_BITS-1:0] new_q;
  logic signed [ACC_W-1:0]       out_i;
  logic signed [ACC_W-1:0]       out_q;
  logic [POS_W-1:0]              out_pos;
  cell_ctrl_t                    ctl;
  wave_t                         wave [MAX_TAPS+1];
  logic signed [SAMPLE_BITS-1:0] hist_i [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_q [MAX_TAPS];

  assign tap_index = s_tdata[5:0];
  assign coef_i    = s_tdata[21:6];
  assign coef_q    = s_tdata[37:22];
  assign new_i     = ctl.zero_in ? '0 : to_hist(s_tdata[53:38]);
  assign new_q     = ctl.zero_in ? '0 : to_hist(s_tdata[69:54]);
  assign m_tdata   = {out_pos, out_q, out_i};

  cfwc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .cmd          (s_tuser[1:0]),
    .first_sample (s_tuser[2]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .out_i        (out_i),
    .out_q        (out_q),
    .out_pos      (out_pos),
    .ctl          (ctl),
    .start        (wave[0]),
    .tail         (wave[MAX_TAPS])
  );

  for (genvar n = 0; n < MAX_TAPS; n++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] in_i;
    logic signed [SAMPLE_BITS-1:0] in_q;

    if (n == 0) begin : g_head
      assign in_i = new_i;
      assign in_q = new_q;
    end else begin : g_body
      assign in_i = ctl.clear ? '0 : hist_i[n-1];
      assign in_q = ctl.clear ? '0 : hist_q[n-1];
    end

    cfwc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (ctl.shift),
      .hist_in_i (in_i),
      .hist_in_q (in_q),
      .load      (ctl.load && (32'(tap_index) == n)),
      .coef_i    (coef_i),
      .coef_q    (coef_q),
      .real_mode (ctl.real_mode),
      .active    (32'(ctl.tap_count) > n),
      .wave_in   (wave[n]),
      .hist_i    (hist_i[n]),
      .hist_q    (hist_q[n]),
      .wave_out  (wave[n+1])
    );
  end

endmodule

// ===== rtl/core/cfwc_checker.sv =====
// ---------------------------------------------------------------------------
// Convolver core checker
// Port-level checks on the request and result channels of the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfwc_checker
  import cfwc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TUSER_W-1:0]  s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result holds.
  `CFWC_ASSERT(a_result_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // A sample or flush request occupies the chain, so the input closes.
  `CFWC_ASSERT(a_busy_after_sample, s_tvalid && s_tready && ((s_tuser[1:0] == CMD_SAMPLE) || (s_tuser[1:0] == CMD_FLUSH)) |=> !s_tready)

  // A tap load leaves the input open for the next request.
  `CFWC_ASSERT(a_load_single_cycle, s_tvalid && s_tready && (s_tuser[1:0] == CMD_LOAD) |=> s_tready)

  // A new result only appears at the end of a sample or flush computation.
  `CFWC_ASSERT(a_result_after_busy, $rose(m_tvalid) |-> !$past(s_tready))

  // Reset leaves no result pending.
  `CFWC_ASSERT_ALWAYS(a_reset_clears, rst |=> !m_tvalid)

endmodule

bind complex_fir_windowed_convolver_core cfwc_checker u_cfwc_checker (.*);

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// Complex FIR windowed convolver core testbench
// Sends tap loads, sample, flush and unused requests through the input stream
// and keeps its own model of the tap store, sample history, position counter
// and registers. Each request that falls in the output window queues an
// expected complex sum, and every result is checked field by field against
// the oldest one. Directed cases come first, then random blocks under several
// idling and back-pressure patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cfwc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = MAX_TAPS + 16;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic                   first;
    logic [TAP_INDEX_W-1:0] tap_index;
    logic signed [15:0]     coef_i;
    logic signed [15:0]     coef_q;
    logic signed [15:0]     sample_i;
    logic signed [15:0]     sample_q;
  } request_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum_i;
    logic signed [ACC_W-1:0] sum_q;
    logic [POS_W-1:0]        pos;
  } conv_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic signed [15:0] coef_store_i [MAX_TAPS] = '{default: '0};
  logic signed [15:0] coef_store_q [MAX_TAPS] = '{default: '0};
  logic signed [15:0] line_i [MAX_TAPS] = '{default: '0};
  logic signed [15:0] line_q [MAX_TAPS] = '{default: '0};
  logic [CNT_W-1:0]   line_pos = '0;

  logic [TAP_COUNT_W-1:0] reg_tap_count = TAP_COUNT_W'(1);
  logic                   reg_taps_real = 1'b0;
  logic [15:0]            reg_window_start = '0;
  logic [15:0]            reg_window_len = '0;

  conv_result_t expected_sums [$];
  int mismatch_count = 0;
  int result_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_id = 0;
  int hold_seen = 0;
  int hold_left = 0;

  complex_fir_windowed_convolver_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    conv_result_t want;
    logic signed [ACC_W-1:0] got_i;
    logic signed [ACC_W-1:0] got_q;
    logic [POS_W-1:0] got_pos;
    got_i = m_tdata[ACC_W-1:0];
    got_q = m_tdata[2*ACC_W-1:ACC_W];
    got_pos = m_tdata[2*ACC_W+POS_W-1:2*ACC_W];
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (expected_sums.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual i %0d q %0d pos %0d",
                 $time, got_i, got_q, got_pos);
      end else begin
        want = expected_sums.pop_front();
        if (got_i !== want.sum_i) begin
          mismatch_count++;
          $display("%0t: out_i mismatch, expected %0d, actual %0d", $time, want.sum_i, got_i);
        end
        if (got_q !== want.sum_q) begin
          mismatch_count++;
          $display("%0t: out_q mismatch, expected %0d, actual %0d", $time, want.sum_q, got_q);
        end
        if (got_pos !== want.pos) begin
          mismatch_count++;
          $display("%0t: out_pos mismatch, expected %0d, actual %0d", $time, want.pos, got_pos);
        end
      end
    end
  end

  task automatic convolve_request(input request_t r);
    longint acc_i;
    longint acc_q;
    longint xi;
    longint xq;
    longint hi;
    longint hq;
    int taps;
    int n;
    int p;
    conv_result_t res;
    acc_i = 0;
    acc_q = 0;
    if (r.cmd == CMD_LOAD) begin
      coef_store_i[r.tap_index] = r.coef_i;
      coef_store_q[r.tap_index] = r.coef_q;
      return;
    end
    if (r.cmd == CMD_UNUSED) return;
    if (r.first) begin
      for (n = 0; n < MAX_TAPS; n++) begin
        line_i[n] = '0;
        line_q[n] = '0;
      end
      line_pos = '0;
    end
    for (n = MAX_TAPS - 1; n > 0; n--) begin
      line_i[n] = line_i[n-1];
      line_q[n] = line_q[n-1];
    end
    line_i[0] = (r.cmd == CMD_SAMPLE) ? r.sample_i : 16'sd0;
    line_q[0] = (r.cmd == CMD_SAMPLE) ? r.sample_q : 16'sd0;
    taps = (int'(reg_tap_count) > MAX_TAPS) ? MAX_TAPS : int'(reg_tap_count);
    for (n = 0; n < taps; n++) begin
      xi = line_i[n];
      xq = line_q[n];
      hi = coef_store_i[n];
      hq = coef_store_q[n];
      if (reg_taps_real) begin
        acc_i += xi * hi;
        acc_q += xq * hi;
      end else begin
        acc_i += xi * hi - xq * hq;
        acc_q += xi * hq + xq * hi;
      end
    end
    p = int'(line_pos);
    if (line_pos != POS_MAX) line_pos++;
    if (p >= int'(reg_window_start) && p - int'(reg_window_start) < int'(reg_window_len)) begin
      res.sum_i = acc_i[ACC_W-1:0];
      res.sum_q = acc_q[ACC_W-1:0];
      res.pos = POS_W'(p - int'(reg_window_start));
      expected_sums.push_back(res);
    end
  endtask

  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, r.sample_q, r.sample_i, r.coef_q, r.coef_i, r.tap_index};
    s_tuser <= {r.first, r.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    convolve_request(r);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= CFG_DATA_W'(value);
    case (index)
      REG_TAP_COUNT:    reg_tap_count = TAP_COUNT_W'(value);
      REG_TAPS_REAL:    reg_taps_real = value[0];
      REG_WINDOW_START: reg_window_start = 16'(value);
      REG_WINDOW_LEN:   reg_window_len = 16'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int taps, input int real_taps, input int start,
                           input int len);
    write_reg(REG_TAP_COUNT, taps);
    write_reg(REG_TAPS_REAL, real_taps);
    write_reg(REG_WINDOW_START, start);
    write_reg(REG_WINDOW_LEN, len);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic request_t make_request(input logic [CMD_W-1:0] cmd, input logic first);
    request_t r;
    r.cmd = cmd;
    r.first = first;
    r.tap_index = TAP_INDEX_W'($urandom_range(MAX_TAPS - 1));
    r.coef_i = pick_word();
    r.coef_q = pick_word();
    r.sample_i = pick_word();
    r.sample_q = pick_word();
    return r;
  endfunction

  function automatic request_t build(input logic [CMD_W-1:0] cmd, input logic first,
                                     input int index, input logic [15:0] a,
                                     input logic [15:0] b);
    request_t r;
    r = make_request(cmd, first);
    r.tap_index = TAP_INDEX_W'(index);
    if (cmd == CMD_LOAD) begin
      r.coef_i = a;
      r.coef_q = b;
    end else begin
      r.sample_i = a;
      r.sample_q = b;
    end
    return r;
  endfunction

  task automatic load_all_taps();
    int n;
    for (n = 0; n < MAX_TAPS; n++) send_request(build(CMD_LOAD, 1'($urandom_range(1)), n,
                                                      pick_word(), pick_word()));
  endtask

  task automatic send_block(input int len, input int flushes, inout int sent);
    int n;
    send_request(make_request(($urandom_range(7) == 0) ? CMD_FLUSH : CMD_SAMPLE, 1'b1));
    sent++;
    for (n = 1; n < len + flushes; n++) begin
      case ($urandom_range(24))
        0: send_request(make_request(CMD_UNUSED, 1'($urandom_range(1))));
        1: begin
          send_request(make_request(CMD_LOAD, 1'($urandom_range(1))));
          sent++;
        end
        2: begin
          send_request(make_request(CMD_SAMPLE, 1'b1));
          sent++;
        end
        default: ;
      endcase
      send_request(make_request((n < len) ? CMD_SAMPLE : CMD_FLUSH, 1'b0));
      sent++;
    end
  endtask

  task automatic run_random(input int target);
    int sent;
    int taps;
    sent = 0;
    while (sent < target) begin
      taps = (int'(reg_tap_count) > MAX_TAPS) ? MAX_TAPS : int'(reg_tap_count);
      send_block($urandom_range(1, 20), $urandom_range(0, ((taps > 24) ? 24 : taps) + 1), sent);
    end
  endtask

  task automatic test_reset_defaults();
    send_request(build(CMD_LOAD, 1'b0, 0, 16'h4000, 16'hc000));
    send_request(build(CMD_SAMPLE, 1'b1, 5, 16'h7fff, 16'h8000));
    send_request(build(CMD_SAMPLE, 1'b0, 9, 16'h1234, 16'hfedc));
    send_request(build(CMD_FLUSH, 1'b0, 0, 16'h0, 16'h0));
    wait_drain();
  endtask

  task automatic test_directed_complex();
    configure(4, 0, 0, 65535);
    send_request(build(CMD_LOAD, 1'b0, 0, 16'h8000, 16'h8000));
    send_request(build(CMD_LOAD, 1'b0, 1, 16'h7fff, 16'h7fff));
    send_request(build(CMD_LOAD, 1'b0, 2, 16'h8000, 16'h7fff));
    send_request(build(CMD_LOAD, 1'b0, 3, 16'h0001, 16'hffff));
    send_request(build(CMD_LOAD, 1'b1, 63, 16'h7fff, 16'h8000));
    send_request(build(CMD_SAMPLE, 1'b1, 0, 16'h8000, 16'h8000));
    send_request(build(CMD_SAMPLE, 1'b0, 63, 16'h7fff, 16'h7fff));
    send_request(build(CMD_SAMPLE, 1'b0, 0, 16'h8000, 16'h7fff));
    send_request(build(CMD_SAMPLE, 1'b0, 0, 16'hffff, 16'h0001));
    send_request(build(CMD_UNUSED, 1'b1, 0, 16'h7fff, 16'h7fff));
    send_request(build(CMD_FLUSH, 1'b0, 0, 16'h7fff, 16'h7fff));
    send_request(build(CMD_FLUSH, 1'b0, 0, 16'h0, 16'h0));
    send_request(build(CMD_FLUSH, 1'b0, 0, 16'h0, 16'h0));
    send_request(build(CMD_FLUSH, 1'b1, 0, 16'h8000, 16'h8000));
    send_request(build(CMD_SAMPLE, 1'b0, 0, 16'h7fff, 16'h8000));
    wait_drain();
  endtask

  task automatic test_directed_real();
    configure(4, 1, 2, 3);
    send_request(build(CMD_SAMPLE, 1'b1, 0, 16'h8000, 16'h7fff));
    send_request(build(CMD_SAMPLE, 1'b0, 0, 16'h7fff, 16'h8000));
    send_request(build(CMD_SAMPLE, 1'b0, 0, 16'h8000, 16'h8000));
    repeat (4) send_request(build(CMD_FLUSH, 1'b0, 0, 16'h0, 16'h0));
    wait_drain();
  endtask

  task automatic test_tap_count_extremes();
    int sent;
    sent = 0;
    load_all_taps();
    wait_drain();
    configure(MAX_TAPS, 0, 0, 65535);
    send_block(6, 4, sent);
    wait_drain();
    configure(127, 1, 0, 65535);
    send_block(4, 2, sent);
    wait_drain();
    configure(0, 0, 0, 65535);
    send_block(3, 1, sent);
    wait_drain();
  endtask

  task automatic test_window_extremes();
    int sent;
    sent = 0;
    configure(2, 0, 65535, 65535);
    send_block(4, 1, sent);
    wait_drain();
    configure(2, 1, 0, 0);
    send_block(4, 1, sent);
    wait_drain();
    configure(3, 0, 3, 1);
    send_block(6, 2, sent);
    wait_drain();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int target);
    int taps;
    int start;
    int len;
    case ($urandom_range(9))
      0: taps = 0;
      1: taps = 1;
      2: taps = MAX_TAPS;
      3: taps = $urandom_range(MAX_TAPS + 1, 127);
      default: taps = $urandom_range(2, 16);
    endcase
    case ($urandom_range(9))
      0: start = 65535;
      1: start = $urandom_range(65535);
      default: start = $urandom_range(0, 6);
    endcase
    case ($urandom_range(9))
      0: len = 0;
      1: len = 65535;
      2: len = $urandom_range(65535);
      default: len = $urandom_range(1, 30);
    endcase
    configure(taps, $urandom_range(1), start, len);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    run_random(target);
    wait_drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    int sent;
    sent = 0;
    configure($urandom_range(1, MAX_TAPS), 0, 0, 65535);
    hold_id <= hold_id + 1;
    send_block(20, 4, sent);
    wait_drain();
    send_block(8, 2, sent);
    wait_drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_directed_complex();
    test_directed_real();
    test_tap_count_extremes();
    test_window_extremes();
    test_backpressure();
    repeat (2) begin
      test_random_phase(0, 0, 60);
      test_random_phase(60, 0, 60);
      test_random_phase(0, 60, 60);
      test_random_phase(35, 35, 60);
    end
    wait_drain();
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cfwc_pkg.sv
rtl/core/cfwc_cell.sv
rtl/core/cfwc_ctrl.sv
rtl/core/complex_fir_windowed_convolver_core.sv
rtl/core/cfwc_checker.sv
tb/sv/tb_top.sv
